[hdl/lis_pkg.sv]
// ----------------------------------------------------------------------------
// lis_pkg
// shared constants for the longest increasing subsequence block
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int CAPACITY    = 256;
  localparam int VALUE_WIDTH = 32;

  // run lengths saturate at the largest value of this width
  localparam int LEN_W   = 9;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // result transfer: length, then overflow, padded to whole bytes
  localparam int OUT_DATA_W = ((LEN_W + 1 + 7) / 8) * 8;

endpackage

[hdl/lis_mem.sv]
// ----------------------------------------------------------------------------
// lis_mem
// element store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module lis_mem #(
  parameter int DEPTH = lis_pkg::CAPACITY,
  parameter int VW    = lis_pkg::VALUE_WIDTH,
  parameter int LW    = lis_pkg::LEN_W,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [VW-1:0] wr_value,
  input  logic [LW-1:0] wr_len,
  input  logic [AW-1:0] rd_addr,
  output logic [VW-1:0] rd_value,
  output logic [LW-1:0] rd_len
);

  logic [VW-1:0] value_mem [DEPTH];
  logic [LW-1:0] len_mem   [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      value_mem[wr_addr] <= wr_value;
      len_mem[wr_addr]   <= wr_len;
    end
    rd_value <= value_mem[rd_addr];
    rd_len   <= len_mem[rd_addr];
  end

endmodule

[hdl/longest_increasing_subsequence.sv]
// ----------------------------------------------------------------------------
// longest_increasing_subsequence
// quadratic dp over a stream of signed values; reports the longest strictly
// increasing subsequence length on the element marked last
// ----------------------------------------------------------------------------
// channel | dir | tdata                         | tlast
// s_*     | in  | value (VALUE_WIDTH, signed)   | last element of sequence
// m_*     | out | length [8:0], overflow [9]    | -
//
// an element holds s_tready low while it scans each stored element through the
// store's single registered read port, writes its value and run, then takes its
// final step; one arriving at a full store is dropped and only takes that step
// s_tready is high only between elements; a result waits in the output register
// and a following last element holds in its final step until that is taken
// synchronous reset clears the sequencer, counters and output valid
// ----------------------------------------------------------------------------
module longest_increasing_subsequence #(
  parameter int CAPACITY    = lis_pkg::CAPACITY,
  parameter int VALUE_WIDTH = lis_pkg::VALUE_WIDTH,
  localparam int IN_W = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [IN_W-1:0]               s_tdata,  // value
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lis_pkg::OUT_DATA_W-1:0] m_tdata  // length, overflow, zero pad
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = lis_pkg::LEN_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  state_t state;
  logic [CW-1:0]          count;
  logic [CW-1:0]          ptr;
  logic                   rd_vld;
  logic [VALUE_WIDTH-1:0] key;
  logic                   last;
  logic [LW-1:0]          run;
  logic [LW-1:0]          best;
  logic                   dropped;

  logic [VALUE_WIDTH-1:0] rd_value;
  logic [LW-1:0]          rd_len;
  logic [LW-1:0]          cand;
  logic                   take;
  logic                   issue;
  logic                   accept;
  logic                   emit;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign issue    = (state == ST_SCAN) && (ptr < count);
  assign emit     = (state == ST_FIN) && last && (!m_tvalid || m_tready);

  // shared compare unit
  assign cand = (rd_len == lis_pkg::LEN_MAX) ? lis_pkg::LEN_MAX : rd_len + 1'b1;
  assign take = rd_vld && ($signed(rd_value) < $signed(key)) && (cand > run);

  lis_mem #(
    .DEPTH (CAPACITY),
    .VW    (VALUE_WIDTH),
    .LW    (LW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (state == ST_WRITE),
    .wr_addr  (count[AW-1:0]),
    .wr_value (key),
    .wr_len   (run),
    .rd_addr  (ptr[AW-1:0]),
    .rd_value (rd_value),
    .rd_len   (rd_len)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      ptr      <= '0;
      rd_vld   <= 1'b0;
      best     <= '0;
      dropped  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            ptr <= '0;
            if (count == CW'(CAPACITY)) begin
              dropped <= 1'b1;
              state   <= ST_FIN;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            ptr <= ptr + 1'b1;
          end else if (!rd_vld) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          count <= count + 1'b1;
          if (run > best) begin
            best <= run;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!last) begin
            state <= ST_IDLE;
          end else if (emit) begin
            m_tvalid <= 1'b1;
            count    <= '0;
            best     <= '0;
            dropped  <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key  <= s_tdata[VALUE_WIDTH-1:0];
      last <= s_tlast;
      run  <= LW'(1);
    end else if (take) begin
      run <= cand;
    end
    if (emit) begin
      m_tdata <= lis_pkg::OUT_DATA_W'({dropped, best});
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("element count beyond capacity");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN || state == ST_WRITE) |-> run != '0)
    else $error("run length zero during scan");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("ready right after an accepted element");

  a_scan_ptr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ptr <= count)
    else $error("scan pointer past stored elements");

  a_result_nonzero: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> m_tdata[LW-1:0] != '0)
    else $error("result length zero");

endmodule

[dv/lis_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lis_checker
// watches both stream channels of the longest increasing subsequence block,
// keeps its own quadratic dp over each sequence and compares every result
// transfer with the oldest predicted one
// ----------------------------------------------------------------------------
module lis_checker import lis_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] s_tdata,  // value
  input  logic                   s_tlast,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_DATA_W-1:0]  m_tdata,  // length, overflow, zero pad
  output int                     fails,
  output int                     pending
);

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             overflow;
  } lis_result_t;

  logic signed [VALUE_WIDTH-1:0] seq_values [CAPACITY];
  logic [LEN_W-1:0]              seq_runs [CAPACITY];
  int                            seq_count;
  logic [LEN_W-1:0]              seq_best;
  logic                          seq_dropped;
  lis_result_t                   expected_lengths_q [$];
  int                            mismatch_count = 0;

  assign fails = mismatch_count;

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic absorb_element(input logic signed [VALUE_WIDTH-1:0] v, input logic fin);
    logic [LEN_W:0] run;
    lis_result_t    res;
    if (seq_count < CAPACITY) begin
      run = 1;
      for (int j = 0; j < seq_count; j++) begin
        if (seq_values[j] < v && seq_runs[j] + 1 > run) begin
          run = seq_runs[j] + 1;
        end
      end
      if (run > LEN_MAX) begin
        run = LEN_MAX;
      end
      seq_values[seq_count] = v;
      seq_runs[seq_count] = run[LEN_W-1:0];
      seq_count++;
      if (run[LEN_W-1:0] > seq_best) begin
        seq_best = run[LEN_W-1:0];
      end
    end else begin
      seq_dropped = 1'b1;
    end
    if (fin) begin
      res.length = seq_best;
      res.overflow = seq_dropped;
      expected_lengths_q.push_back(res);
      seq_count = 0;
      seq_best = '0;
      seq_dropped = 1'b0;
    end
  endtask

  task automatic check_result(input logic [OUT_DATA_W-1:0] beat);
    lis_result_t want;
    if (expected_lengths_q.size() == 0) begin
      report_mismatch("unexpected result transfer, length", beat[LEN_W-1:0], 0);
    end else begin
      want = expected_lengths_q.pop_front();
      if (beat[LEN_W-1:0] !== want.length) begin
        report_mismatch("length", beat[LEN_W-1:0], want.length);
      end
      if (beat[LEN_W] !== want.overflow) begin
        report_mismatch("overflow", beat[LEN_W], want.overflow);
      end
      if (beat[OUT_DATA_W-1:LEN_W+1] !== '0) begin
        report_mismatch("padding", beat[OUT_DATA_W-1:LEN_W+1], 0);
      end
    end
  endtask

  // result side first: a result leaving at this edge belongs to an older sequence
  always @(posedge clk) begin
    if (rst) begin
      seq_count = 0;
      seq_best = '0;
      seq_dropped = 1'b0;
      expected_lengths_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        check_result(m_tdata);
      end
      if (s_tvalid && s_tready) begin
        absorb_element($signed(s_tdata[VALUE_WIDTH-1:0]), s_tlast);
      end
    end
    pending <= expected_lengths_q.size();
  end

endmodule

[dv/tb_longest_increasing_subsequence.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_increasing_subsequence
// drives directed and random sequences of signed values into the block with
// random gaps and output stalls; a checker beside the block predicts each
// sequence result and counts mismatches
// ----------------------------------------------------------------------------
module tb_longest_increasing_subsequence;
  import lis_pkg::*;

  localparam int IN_W         = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int TOTAL_ITEMS  = 1950;
  localparam int CALM_ITEMS   = 300;
  localparam int DRAIN_CYCLES = 4 * (CAPACITY + 3);

  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};

  typedef enum int {
    STYLE_WIDE,
    STYLE_NARROW,
    STYLE_RISING,
    STYLE_NOISY_RISE,
    STYLE_FALLING,
    STYLE_EXTREME
  } seq_style_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;  // value
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;       // length, overflow, zero pad
  logic                  calm = 1'b0;
  int                    stall_left = 0;
  int                    stored_items = 0;
  int                    fails;
  int                    pending;

  longest_increasing_subsequence u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  lis_checker u_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .fails    (fails),
    .pending  (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("[longest_increasing_subsequence] ERROR");
    $finish;
  end

  // output stalls in bursts, none once the run turns calm
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (!rst && !calm && $urandom_range(0, 11) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(1, 9) - 1;
    end else begin
      m_tready <= !rst;
    end
  end

  function automatic logic signed [VALUE_WIDTH-1:0] pick_value(input seq_style_t style,
                                                               input int pos);
    case (style)
      STYLE_NARROW:     return int'($urandom_range(0, 8)) - 4;
      STYLE_RISING:     return pos * 16 + int'($urandom_range(0, 15)) - 2048;
      STYLE_NOISY_RISE: return pos * 16 + int'($urandom_range(0, 63)) - 2048;
      STYLE_FALLING:    return 2048 - pos * 16 - int'($urandom_range(0, 31));
      STYLE_EXTREME: begin
        case ($urandom_range(0, 6))
          0:       return VMIN;
          1:       return VMIN + 1;
          2:       return -1;
          3:       return 0;
          4:       return 1;
          5:       return VMAX - 1;
          default: return VMAX;
        endcase
      end
      default:          return $urandom();
    endcase
  endfunction

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic send_element(input logic signed [VALUE_WIDTH-1:0] v, input logic fin);
    sender_gap();
    s_tvalid <= 1'b1;
    s_tdata <= IN_W'(v);
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_sequence(input int len, input seq_style_t style);
    for (int pos = 0; pos < len; pos++) begin
      send_element(pick_value(style, pos), pos == len - 1);
      if (pos < CAPACITY) begin
        stored_items++;
      end
    end
  endtask

  task automatic wait_results_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single element at either extreme
    send_element(VMAX, 1'b1);
    send_element(VMIN, 1'b1);
    // full span rising
    send_element(VMIN, 1'b0);
    send_element(-1, 1'b0);
    send_element(0, 1'b0);
    send_element(1, 1'b0);
    send_element(VMAX, 1'b1);
    // equal values never extend a run
    send_element(7, 1'b0);
    send_element(7, 1'b0);
    send_element(7, 1'b1);
    // falling across the range
    send_element(VMAX, 1'b0);
    send_element(0, 1'b0);
    send_element(VMIN, 1'b1);
    // mixed order
    send_element(3, 1'b0);
    send_element(1, 1'b0);
    send_element(2, 1'b0);
    send_element(1, 1'b0);
    send_element(4, 1'b0);
    send_element(0, 1'b0);
    send_element(5, 1'b1);
    stored_items = 20;

    s_tvalid <= 1'b0;
    wait_results_drained();

    // full store, then past capacity with the elements beyond it dropped
    send_sequence(CAPACITY, STYLE_RISING);
    send_sequence(CAPACITY + 6, STYLE_NOISY_RISE);
    send_sequence(CAPACITY + 1, STYLE_WIDE);

    while (stored_items < TOTAL_ITEMS) begin
      calm <= (stored_items >= TOTAL_ITEMS - CALM_ITEMS);
      if ($urandom_range(0, 40) == 0) begin
        len = $urandom_range(CAPACITY - 2, CAPACITY + 8);
      end else begin
        len = $urandom_range(1, 24);
      end
      send_sequence(len, seq_style_t'($urandom_range(0, 5)));
    end

    s_tvalid <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("[longest_increasing_subsequence] OK");
    end else begin
      $display("[longest_increasing_subsequence] ERROR");
    end
    $finish;
  end

endmodule
